// File: rtl/affine_point_transform_defines.svh
`ifndef AFFINE_POINT_TRANSFORM_DEFINES_SVH
`define AFFINE_POINT_TRANSFORM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define APT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("affine_point_transform: check failed");

// Next-cycle implication, checked outside reset.
`define APT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("affine_point_transform: check failed");

`endif

// File: rtl/apt_pkg.sv
package apt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int CFG_W     = 2 * COORD_W;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int TSH_W     = COORD_W + FRAC_BITS;
	localparam int SUM_W     = PROD_W + 2;
	localparam int SHR_W     = SUM_W - FRAC_BITS;
	localparam int ROWS      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_AB = 3'd0,
		REG_ROW0_CD = 3'd1,
		REG_ROW1_AB = 3'd2,
		REG_ROW1_CD = 3'd3,
		REG_ROW2_AB = 3'd4,
		REG_ROW2_CD = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] t;
		logic signed [COORD_W-1:0] m2;
		logic signed [COORD_W-1:0] m1;
		logic signed [COORD_W-1:0] m0;
	} coef_row_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	localparam logic signed [COORD_W-1:0] Q_ONE = COORD_W'(1) << FRAC_BITS;
	localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// The identity matrix, loaded at reset.
	localparam coef_row_t [ROWS-1:0] COEF_RESET = {
		{{COORD_W{1'b0}}, Q_ONE, {COORD_W{1'b0}}, {COORD_W{1'b0}}},
		{{COORD_W{1'b0}}, {COORD_W{1'b0}}, Q_ONE, {COORD_W{1'b0}}},
		{{COORD_W{1'b0}}, {COORD_W{1'b0}}, {COORD_W{1'b0}}, Q_ONE}
	};

endpackage

// File: rtl/apt_coef_regs.sv
module apt_coef_regs import apt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output coef_row_t [ROWS-1:0] coef
);

	coef_row_t [ROWS-1:0] coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_ROW0_AB: {coef_q[0].m1, coef_q[0].m0} <= wr_data;
				REG_ROW0_CD: {coef_q[0].t,  coef_q[0].m2} <= wr_data;
				REG_ROW1_AB: {coef_q[1].m1, coef_q[1].m0} <= wr_data;
				REG_ROW1_CD: {coef_q[1].t,  coef_q[1].m2} <= wr_data;
				REG_ROW2_AB: {coef_q[2].m1, coef_q[2].m0} <= wr_data;
				REG_ROW2_CD: {coef_q[2].t,  coef_q[2].m2} <= wr_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

// File: rtl/apt_row_dp.sv
module apt_row_dp import apt_pkg::*; (
	input  logic                      clk,
	input  stage_en_t                 en,
	input  coef_row_t                 coef,
	input  logic signed [COORD_W-1:0] px,
	input  logic signed [COORD_W-1:0] py,
	input  logic signed [COORD_W-1:0] pz,
	output logic signed [COORD_W-1:0] q_s3,
	output logic                      sat_s3
);

	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [TSH_W-1:0]  t_s1;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [SHR_W-1:0]  shr;
	logic                     all_ones, all_zeros;

	// Stage 1: the three products and the aligned translation.
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			p0_s1 <= coef.m0 * px;
			p1_s1 <= coef.m1 * py;
			p2_s1 <= coef.m2 * pz;
			t_s1  <= TSH_W'(coef.t) <<< FRAC_BITS;
		end
	end

	// Stage 2: exact sum.
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			sum_s2 <= SUM_W'(p0_s1) + SUM_W'(p1_s1) + SUM_W'(p2_s1) + SUM_W'(t_s1);
		end
	end

	// Stage 3: arithmetic shift and saturation.
	always_comb begin
		shr       = SHR_W'(sum_s2 >>> FRAC_BITS);
		all_ones  = &shr[SHR_W-1:COORD_W-1];
		all_zeros = ~|shr[SHR_W-1:COORD_W-1];
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			if (all_ones || all_zeros) begin
				q_s3   <= shr[COORD_W-1:0];
				sat_s3 <= 1'b0;
			end else begin
				q_s3   <= shr[SHR_W-1] ? Q_MIN : Q_MAX;
				sat_s3 <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/affine_point_transform.sv
// Affine point transform: each point (x, y, z) on the slave stream leaves on
// the master stream as the product with the upper three rows of a 4x4 matrix.
// Coordinates and coefficients are signed Q16.16; each sum is shifted right by
// the fraction width, saturated to 32 bits, and m_tuser flags any clamping.
// The slave tlast is carried unchanged to the master tlast.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// one 64-bit coefficient register per transfer; cfg_ready is always high and
// indexes above five are ignored. Write it only while the pipeline is empty.
// From the slave transfer to m_tvalid a point passes a multiply stage,
// a summing stage and a shift-and-saturate stage. Throughput is one point
// per cycle while the receiver does not stall.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, each stage holds until the next frees up; s_tready
// drops only once all three stages are full.
`include "affine_point_transform_defines.svh"

module affine_point_transform import apt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [3*COORD_W-1:0]   s_tdata,   // px, py, pz
	input  logic                   s_tlast,   // in_last
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [3*COORD_W-1:0]   m_tdata,   // qx, qy, qz
	output logic                   m_tuser,   // clamped
	output logic                   m_tlast,   // out_last
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	coef_row_t [ROWS-1:0]      coef;
	stage_en_t                 en;
	logic                      valid_s1, valid_s2, valid_s3;
	logic                      last_s1, last_s2, last_s3;
	logic                      rdy1, rdy2, rdy3;
	logic signed [COORD_W-1:0] q_s3 [ROWS];
	logic [ROWS-1:0]           sat_s3;

	assign cfg_ready = 1'b1;

	apt_coef_regs u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	assign rdy3     = !valid_s3 || m_tready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	assign en.en_s1 = rdy1;
	assign en.en_s2 = rdy2;
	assign en.en_s3 = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) last_s1 <= s_tlast;
		if (rdy2) last_s2 <= last_s1;
		if (rdy3) last_s3 <= last_s2;
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		apt_row_dp u_row (
			.clk    (clk),
			.en     (en),
			.coef   (coef[r]),
			.px     (s_tdata[COORD_W-1:0]),
			.py     (s_tdata[2*COORD_W-1:COORD_W]),
			.pz     (s_tdata[3*COORD_W-1:2*COORD_W]),
			.q_s3   (q_s3[r]),
			.sat_s3 (sat_s3[r])
		);
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {q_s3[2], q_s3[1], q_s3[0]};
	assign m_tuser  = |sat_s3;
	assign m_tlast  = last_s3;

	`APT_ASSERT_NOW(a_full_stall, valid_s1 && valid_s2 && valid_s3 && !m_tready, !s_tready)
	`APT_ASSERT_NOW(a_room_accepts, !valid_s1, s_tready)
	`APT_ASSERT_NOW(a_clamp_extreme, m_tvalid && m_tuser,
		(q_s3[0] == Q_MAX) || (q_s3[0] == Q_MIN) || (q_s3[1] == Q_MAX) ||
		(q_s3[1] == Q_MIN) || (q_s3[2] == Q_MAX) || (q_s3[2] == Q_MIN))
	`APT_ASSERT_NEXT(a_bubble_fill, valid_s2 && !valid_s3, valid_s3)

endmodule

// File: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import apt_pkg::*;

	localparam int ACC_W = PROD_W + 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASES = 6;
	localparam int POINTS_PER_PHASE = 115;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE, VAL_MID, VAL_ANY} value_kind_t;

	typedef struct {
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;
		logic [COORD_W-1:0] qz;
		logic               clamped;
		logic               last;
	} point_result_t;

	class transform_scoreboard;
		logic [CFG_W-1:0] coef_regs [ROWS*2];
		point_result_t    expected_points [$];
		int               mismatches;

		function new();
			coef_regs[REG_ROW0_AB] = {32'h0, Q_ONE};
			coef_regs[REG_ROW0_CD] = '0;
			coef_regs[REG_ROW1_AB] = {Q_ONE, 32'h0};
			coef_regs[REG_ROW1_CD] = '0;
			coef_regs[REG_ROW2_AB] = '0;
			coef_regs[REG_ROW2_CD] = {32'h0, Q_ONE};
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx <= REG_ROW2_CD)
				coef_regs[idx] = val;
		endfunction

		function logic [COORD_W-1:0] eval_row(int row, logic [COORD_W-1:0] x, y, z,
				inout bit sat);
			logic [CFG_W-1:0] ab;
			logic [CFG_W-1:0] cd;
			logic signed [ACC_W-1:0] m0, m1, m2, t, sx, sy, sz, acc, lim_hi, lim_lo;
			ab = coef_regs[2*row];
			cd = coef_regs[2*row+1];
			m0 = $signed(ab[COORD_W-1:0]);
			m1 = $signed(ab[CFG_W-1:COORD_W]);
			m2 = $signed(cd[COORD_W-1:0]);
			t = $signed(cd[CFG_W-1:COORD_W]);
			sx = $signed(x);
			sy = $signed(y);
			sz = $signed(z);
			lim_hi = Q_MAX;
			lim_lo = Q_MIN;
			acc = m0 * sx + m1 * sy + m2 * sz + (t <<< FRAC_BITS);
			acc = acc >>> FRAC_BITS;
			if (acc > lim_hi) begin
				sat = 1'b1;
				return Q_MAX;
			end
			if (acc < lim_lo) begin
				sat = 1'b1;
				return Q_MIN;
			end
			return acc[COORD_W-1:0];
		endfunction

		function void note_point(logic [COORD_W-1:0] x, y, z, logic last);
			point_result_t r;
			bit sat;
			sat = 1'b0;
			r.qx = eval_row(0, x, y, z, sat);
			r.qy = eval_row(1, x, y, z, sat);
			r.qz = eval_row(2, x, y, z, sat);
			r.clamped = sat;
			r.last = last;
			expected_points.push_back(r);
		endfunction

		function void check_point(logic [3*COORD_W-1:0] data, logic user, logic last);
			point_result_t want;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result q=%h clamped=%b last=%b with no point pending",
						$realtime, data, user, last);
				return;
			end
			want = expected_points.pop_front();
			if (data !== {want.qz, want.qy, want.qx} || user !== want.clamped ||
					last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected q=(%h %h %h) clamped=%b last=%b, got q=(%h %h %h) clamped=%b last=%b",
						$realtime, want.qx, want.qy, want.qz, want.clamped, want.last,
						data[COORD_W-1:0], data[2*COORD_W-1:COORD_W],
						data[3*COORD_W-1:2*COORD_W], user, last);
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [3*COORD_W-1:0] s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [3*COORD_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	transform_scoreboard sb = new();
	bit gaps_on = 1'b1;
	int stall_left = 0;
	int cycles = 0;

	affine_point_transform dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_point(m_tdata, m_tuser, m_tlast);
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [COORD_W-1:0] pick_value(value_kind_t kind);
		logic [COORD_W-1:0] r;
		r = $urandom;
		case (kind)
			VAL_NARROW: return {{13{r[18]}}, r[18:0]};
			VAL_MID: return {{8{r[23]}}, r[23:0]};
			VAL_EDGE: begin
				case ($urandom_range(0, 5))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					3: return Q_ONE;
					4: return -Q_ONE;
					default: return '1;
				endcase
			end
			VAL_ANY: return pick_value(value_kind_t'($urandom_range(0, 3)));
			default: return r;
		endcase
	endfunction

	task automatic send_point(input logic [COORD_W-1:0] x, y, z, input logic last);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_point(x, y, z, last);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic load_matrix(input logic [CFG_W-1:0] vals [ROWS*2], input bit spare);
		for (int i = 0; i < ROWS*2; i++)
			put_reg(CFG_IDX_W'(i), vals[i]);
		if (spare)
			put_reg($urandom_range(0, 1) ? REG_SPARE7 : REG_SPARE6, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_points();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] mat [ROWS*2];
		value_kind_t phase_kinds [RANDOM_PHASES];
		value_kind_t coef_kind;
		phase_kinds = '{VAL_NARROW, VAL_WIDE, VAL_EDGE, VAL_NARROW, VAL_MID, VAL_NARROW};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset matrix is the identity, so every point passes unchanged.
		send_point('0, '0, '0, 1'b0);
		send_point(Q_MAX, Q_MIN, '1, 1'b1);
		send_point(Q_MIN, Q_MAX, 32'h1, 1'b0);
		send_point(32'h5555_AAAA, 32'hAAAA_5555, 32'h0001_8000, 1'b1);
		drain_points();

		// Full-scale coefficients and translations drive both saturation limits.
		mat = '{{Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN},
			{32'h0, 32'h0}, {32'hFFFF_FFFF, 32'h0}};
		load_matrix(mat, 1'b1);
		send_point('0, '0, '0, 1'b0);
		send_point(32'h1, '0, '0, 1'b1);
		send_point(Q_MAX, Q_MAX, Q_MAX, 1'b0);
		send_point(Q_MIN, Q_MIN, Q_MIN, 1'b1);
		send_point('1, '1, '1, 1'b0);
		drain_points();

		// All ones: the smallest negative coefficient shows the floor rounding.
		mat = '{'1, '1, '1, '1, '1, '1};
		load_matrix(mat, 1'b1);
		send_point(32'h1, '0, '0, 1'b0);
		send_point('0, '0, '0, 1'b1);
		send_point(Q_MIN, Q_MIN, Q_MIN, 1'b0);
		send_point(Q_MAX, '0, '0, 1'b1);
		drain_points();

		// Negating the most negative coordinate overflows by one step.
		mat = '{{32'h0, 32'h1}, {32'h0, 32'h0}, {-Q_ONE, 32'h0}, {32'h0, 32'h0},
			{32'h0, 32'h0}, {Q_MAX, 32'h0002_0000}};
		load_matrix(mat, 1'b0);
		send_point('1, Q_MIN, Q_MAX, 1'b0);
		send_point(Q_MAX, 32'h1, '1, 1'b1);
		send_point(32'h0000_8000, -32'sh8000, '0, 1'b0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_points();
			gaps_on = (phase != 2) && (phase < RANDOM_PHASES - 1);
			coef_kind = phase_kinds[phase];
			for (int r = 0; r < ROWS*2; r++)
				mat[r] = {pick_value(coef_kind), pick_value(coef_kind)};
			load_matrix(mat, $urandom_range(0, 1));
			repeat (POINTS_PER_PHASE)
				send_point(pick_value(VAL_ANY), pick_value(VAL_ANY), pick_value(VAL_ANY),
					$urandom_range(0, 7) == 0);
		end

		drain_points();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
